@@ hdl/fsp_pkg.sv @@
// Package for the frame start pacer: opcodes, controller states, command and
// status structs, and fixed constants.
// No dependencies.
package fsp_pkg;

    localparam int          TIME_W        = 64;
    localparam int          RATE_W        = 10;
    localparam int          PERIOD_W      = 30;
    localparam int          DIV_CNT_W     = 5;
    localparam logic [RATE_W-1:0]   MAX_RATE      = 10'd1000;
    localparam logic [PERIOD_W-1:0] NS_PER_SECOND = 30'd1000000000;
    localparam logic [PERIOD_W-3:0] MAX_CORR_NS   = 28'd1000000;
    localparam logic [RATE_W-1:0]   RATE_RESET    = 10'd60;

    typedef enum logic [1:0] {
        OP_PREPARE = 2'd0,
        OP_ACCEPT  = 2'd1,
        OP_DISABLE = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic {
        RES_NOW = 1'b0,
        RES_MAX = 1'b1
    } res_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIV,
        ST_RESYNC,
        ST_PREP,
        ST_ACC_LATE,
        ST_ACC_STEP,
        ST_ACC_ADD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic     load;
        logic     div_start;
        logic     div_step;
        logic     resync;
        logic     clear_init;
        logic     prep_add;
        logic     late_cmp;
        logic     acc_step;
        logic     acc_commit;
        logic     out_load;
        res_sel_t res_sel;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic rate_ok;
        logic init;
        logic now_lt_last;
        logic div_last;
        logic out_free;
    } stat_t;

endpackage

@@ hdl/fsp_div.sv @@
// Restoring divider, one quotient bit per cycle while step is high: one billion / rate.
// Depends on fsp_pkg.
module fsp_div
    import fsp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                step,
    input  logic [RATE_W-1:0]   divisor,
    output logic [PERIOD_W-1:0] quotient,
    output logic [RATE_W-1:0]   remainder,
    output logic                last
);

    localparam logic [DIV_CNT_W-1:0] LAST_CNT = DIV_CNT_W'(PERIOD_W - 1);

    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [RATE_W-1:0]    rem_reg, rem_next;
    logic [PERIOD_W-1:0]  quo_reg, quo_next;
    logic [RATE_W:0]      trial;
    logic                 qbit;
    logic [DIV_CNT_W-1:0] bit_idx;

    assign last     = (cnt_reg == LAST_CNT);
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    // dividend bits fed MSB first
    assign bit_idx = LAST_CNT - cnt_reg;
    assign trial   = {rem_reg, NS_PER_SECOND[bit_idx]};
    assign qbit    = (trial >= {1'b0, divisor});

    always_comb
    begin
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (start)
        begin
            cnt_next = '0;
            rem_next = '0;
        end
        else if (step)
        begin
            rem_next = qbit ? RATE_W'(trial - {1'b0, divisor}) : trial[RATE_W-1:0];
            quo_next = {quo_reg[PERIOD_W-2:0], qbit};
            if (!last)
                cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= LAST_CNT)
        else $error("divider step count out of range");

endmodule

@@ hdl/fsp_dp.sv @@
// Pacer datapath: rate register, schedule state, divider, saturating adders
// and the output register. Depends on fsp_pkg and fsp_div.
module fsp_dp
    import fsp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [RATE_W-1:0] cfg_wdata,
    input  logic [1:0]        in_op,
    input  logic [TIME_W-1:0] in_now,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [TIME_W-1:0] out_data,
    input  cmd_t              cmd,
    output stat_t             stat
);

    logic [RATE_W-1:0]   fps_reg;
    logic                init_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [RATE_W-1:0]   frac_reg;
    logic [RATE_W-1:0]   acc_reg;
    logic [TIME_W-1:0]   next_ideal_reg;
    logic [TIME_W-1:0]   last_start_reg;
    op_t                 op_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [TIME_W-1:0]   earliest_reg;
    logic                late_reg;
    logic [PERIOD_W-1:0] step_reg;
    logic                out_valid_reg;
    logic [TIME_W-1:0]   out_data_reg;

    logic [PERIOD_W-1:0] div_quo;
    logic [RATE_W-1:0]   div_rem;
    logic                div_last;

    logic [PERIOD_W-3:0] quarter, corr;
    logic [PERIOD_W-1:0] gap;
    logic [TIME_W:0]     earliest_sum;
    logic [TIME_W:0]     late_limit;
    logic [RATE_W:0]     acc_sum;
    logic                wrap;
    logic [TIME_W-1:0]   adv_base;
    logic [TIME_W:0]     adv_sum;
    logic [TIME_W-1:0]   res_val;

    fsp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .step      (cmd.div_step),
        .divisor   (fps_reg),
        .quotient  (div_quo),
        .remainder (div_rem),
        .last      (div_last)
    );

    // earliest = last start + period - min(period/4, 1 ms), saturating
    assign quarter      = period_reg[PERIOD_W-1:2];
    assign corr         = (quarter > MAX_CORR_NS) ? MAX_CORR_NS : quarter;
    assign gap          = period_reg - {2'b00, corr};
    assign earliest_sum = {1'b0, last_start_reg} + (TIME_W+1)'(gap);

    // a full period late when now >= ideal + period (period is nonzero once initialised)
    assign late_limit = {1'b0, next_ideal_reg} + (TIME_W+1)'(period_reg);

    assign acc_sum = (late_reg ? '0 : {1'b0, acc_reg}) + {1'b0, frac_reg};
    assign wrap    = (acc_sum >= {1'b0, fps_reg});

    assign adv_base = late_reg ? now_reg : next_ideal_reg;
    assign adv_sum  = {1'b0, adv_base} + (TIME_W+1)'(step_reg);

    assign res_val = (cmd.res_sel == RES_NOW) ? now_reg :
                     (next_ideal_reg < earliest_reg) ? earliest_reg : next_ideal_reg;

    assign stat.op          = op_reg;
    assign stat.rate_ok     = (fps_reg != '0) && (fps_reg <= MAX_RATE);
    assign stat.init        = init_reg;
    assign stat.now_lt_last = (now_reg < last_start_reg);
    assign stat.div_last    = div_last;
    assign stat.out_free    = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fps_reg       <= RATE_RESET;
            init_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                fps_reg <= cfg_wdata;

            if (cfg_we || cmd.clear_init)
                init_reg <= 1'b0;
            else if (cmd.resync)
                init_reg <= 1'b1;

            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // schedule state; only meaningful while init_reg is set
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg     <= '0;
            frac_reg       <= '0;
            acc_reg        <= '0;
            next_ideal_reg <= '0;
            last_start_reg <= '0;
        end
        else
        begin
            if (cmd.resync)
            begin
                period_reg     <= div_quo;
                frac_reg       <= div_rem;
                acc_reg        <= '0;
                next_ideal_reg <= now_reg;
                last_start_reg <= now_reg;
            end
            if (cmd.acc_step)
                acc_reg <= wrap ? RATE_W'(acc_sum - {1'b0, fps_reg}) : acc_sum[RATE_W-1:0];
            if (cmd.acc_commit)
            begin
                next_ideal_reg <= adv_sum[TIME_W] ? '1 : adv_sum[TIME_W-1:0];
                last_start_reg <= now_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= op_t'(in_op);
            now_reg <= in_now;
        end
        if (cmd.prep_add)
            earliest_reg <= earliest_sum[TIME_W] ? '1 : earliest_sum[TIME_W-1:0];
        if (cmd.late_cmp)
            late_reg <= ({1'b0, now_reg} >= late_limit);
        if (cmd.acc_step)
            step_reg <= period_reg + PERIOD_W'(wrap);
        if (cmd.out_load)
            out_data_reg <= res_val;
    end

    a_period_set: assert property (@(posedge clk) disable iff (!rst_n)
        init_reg |-> (period_reg != '0))
        else $error("initialised with zero period");

    a_acc_below_rate: assert property (@(posedge clk) disable iff (!rst_n)
        init_reg |-> (acc_reg < fps_reg))
        else $error("fraction accumulator not below rate");

endmodule

@@ hdl/fsp_ctrl.sv @@
// Pacer controller: sequences decode, division, prepare and accept steps.
// Depends on fsp_pkg.
module fsp_ctrl
    import fsp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t   state_reg, state_next;
    res_sel_t sel_reg, sel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sel_reg   <= RES_NOW;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        sel_next    = sel_reg;
        cmd         = '0;
        cmd.res_sel = sel_reg;
        in_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (stat.op)
                    OP_PREPARE:
                    begin
                        if (!stat.rate_ok)
                        begin
                            cmd.clear_init = 1'b1;
                            sel_next       = RES_NOW;
                            state_next     = ST_OUT;
                        end
                        else if (!stat.init || stat.now_lt_last)
                        begin
                            cmd.div_start = 1'b1;
                            state_next    = ST_DIV;
                        end
                        else
                            state_next = ST_PREP;
                    end
                    OP_ACCEPT:
                    begin
                        if (!stat.init)
                            state_next = ST_IDLE;
                        else if (stat.now_lt_last)
                        begin
                            cmd.clear_init = 1'b1;
                            state_next     = ST_IDLE;
                        end
                        else
                            state_next = ST_ACC_LATE;
                    end
                    OP_DISABLE:
                    begin
                        cmd.clear_init = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    OP_NONE:
                        state_next = ST_IDLE;
                    default:
                        state_next = ST_IDLE;
                endcase
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                    state_next = ST_RESYNC;
            end
            ST_RESYNC:
            begin
                cmd.resync = 1'b1;
                sel_next   = RES_NOW;
                state_next = ST_OUT;
            end
            ST_PREP:
            begin
                cmd.prep_add = 1'b1;
                sel_next     = RES_MAX;
                state_next   = ST_OUT;
            end
            ST_ACC_LATE:
            begin
                cmd.late_cmp = 1'b1;
                state_next   = ST_ACC_STEP;
            end
            ST_ACC_STEP:
            begin
                cmd.acc_step = 1'b1;
                state_next   = ST_ACC_ADD;
            end
            ST_ACC_ADD:
            begin
                cmd.acc_commit = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("result loaded over a pending transfer");

    a_resync_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.resync |-> ($past(cmd.div_step) && $past(stat.div_last)))
        else $error("resync without a finished division");

endmodule

@@ hdl/frame_start_pacer.sv @@
// Frame start pacer top level: stream ports, rate register port, controller
// and datapath. Depends on fsp_pkg, fsp_ctrl, fsp_dp.
//
// Takes one operation at a time (prepare, accept, disable) with the current
// time in ns, and answers each prepare with the earliest start time of the
// next frame. A prepare on an initialised pacer runs decode, prepare and
// output states; one that resynchronises first runs the divider, forming one
// billion / frames_per_second one quotient bit per cycle over 30 bits; one at
// an out-of-range rate goes from decode to output. An accept that advances
// the schedule runs late check, accumulator step and add states; an ignored
// accept, a disable or an unused opcode returns to idle from decode. A result
// sits in an output register, so the next operation is taken while it waits.
// Writing frames_per_second (only while idle) forces a resync on the next
// prepare; a rate of 0 or above 1000 passes now_ns through unpaced.
module frame_start_pacer
    import fsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [9:0]  cfg_wdata,      // frames_per_second
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] now_ns
    input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // [63:0] start_target_ns
);

    cmd_t  cmd;
    stat_t stat;

    fsp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fsp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_op     (s_axis_tuser),
        .in_now    (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

@@ verif/frame_start_pacer_tb.sv @@
// Self-checking testbench for frame_start_pacer: frame loops and noise on the stream ports,
// rate changes, and every start time checked against an in-bench prediction.
// Depends on fsp_pkg and the frame_start_pacer RTL.
module frame_start_pacer_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fsp_pkg::*;

    localparam int          SETTLE_CYCLES = 40;
    localparam int          CYCLE_LIMIT   = 500_000;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          CORR_DIV      = 4;
    localparam logic [63:0] TIME_MAX      = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] DEFAULT_GAP   = 64'd16_666_666;

    // Tracks the pacer state and the start times still owed by the block.
    class start_time_tracker;
        logic [9:0]  rate;
        bit          synced;
        logic [29:0] period;
        logic [9:0]  frac;
        logic [9:0]  frac_acc;
        logic [63:0] next_ideal;
        logic [63:0] last_start;
        logic [63:0] start_targets_q[$];
        int          errors;

        function new();
            rate       = RATE_RESET;
            synced     = 1'b0;
            period     = '0;
            frac       = '0;
            frac_acc   = '0;
            next_ideal = '0;
            last_start = '0;
            errors     = 0;
        endfunction

        function void write_rate(logic [9:0] value);
            rate   = value;
            synced = 1'b0;
        endfunction

        function logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
            logic [64:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[64] ? TIME_MAX : s[63:0];
        endfunction

        // Period plus one ns each time the remainder accumulator wraps.
        function logic [63:0] frame_interval();
            int unsigned sum;
            logic [63:0] step;
            step = 64'(period);
            sum  = frac_acc + frac;
            if (sum >= rate)
            begin
                sum  = sum - rate;
                step = step + 1;
            end
            frac_acc = 10'(sum);
            return step;
        endfunction

        function logic [63:0] prepare_target(logic [63:0] now);
            logic [63:0] corr;
            logic [63:0] earliest;
            if (rate == 0 || rate > MAX_RATE)
            begin
                synced = 1'b0;
                return now;
            end
            if (!synced || now < last_start)
            begin
                synced     = 1'b1;
                period     = NS_PER_SECOND / rate;
                frac       = 10'(NS_PER_SECOND % rate);
                frac_acc   = '0;
                next_ideal = now;
                last_start = now;
                return now;
            end
            corr = 64'(period / CORR_DIV);
            if (corr > MAX_CORR_NS)
                corr = 64'(MAX_CORR_NS);
            earliest = sat_sum(last_start, period - corr);
            return (next_ideal < earliest) ? earliest : next_ideal;
        endfunction

        function void accept_start(logic [63:0] now);
            logic [63:0] late;
            if (!synced)
                return;
            if (now < last_start)
            begin
                synced = 1'b0;
                return;
            end
            late       = (now > next_ideal) ? now - next_ideal : '0;
            last_start = now;
            if (late >= period)
            begin
                // a full period late: schedule restarts from now
                frac_acc   = '0;
                next_ideal = sat_sum(now, frame_interval());
            end
            else
                next_ideal = sat_sum(next_ideal, frame_interval());
        endfunction

        function void note_input(op_t op, logic [63:0] now);
            case (op)
                OP_PREPARE: start_targets_q.push_back(prepare_target(now));
                OP_ACCEPT:  accept_start(now);
                OP_DISABLE: synced = 1'b0;
                default:    ;
            endcase
        endfunction

        function void check_result(logic [63:0] got);
            logic [63:0] want;
            if (start_targets_q.size() == 0)
            begin
                $error("start_target_ns: none expected, actual %0d", got);
                errors++;
                return;
            end
            want = start_targets_q.pop_front();
            if (got !== want)
            begin
                $error("start_target_ns: expected %0d, actual %0d", want, got);
                errors++;
            end
        endfunction

        function int pending();
            return start_targets_q.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [9:0]  cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // [63:0] now_ns
    logic [1:0]  s_axis_tuser;   // [1:0] opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // [63:0] start_target_ns

    start_time_tracker tracker = new();

    int          tx_idle_pct;
    int          rx_idle_pct;
    int          rx_hold_left;
    int          cycle_count;
    logic [9:0]  cur_rate;
    logic [63:0] now_cursor;

    frame_start_pacer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && s_axis_tvalid && s_axis_tready)
            tracker.note_input(op_t'(s_axis_tuser), s_axis_tdata);

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_result(m_axis_tdata);

    // Receiver: random stalls, or a long hold-off when one is requested.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                rx_hold_left--;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    function automatic logic [63:0] later(logic [63:0] t, logic [63:0] d);
        return (t > TIME_MAX - d) ? TIME_MAX : t + d;
    endfunction

    task automatic send_op(input op_t op, input logic [63:0] now);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= now;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Stop offering, wait for every owed start time, then let the block settle.
    task automatic wait_drained(input int settle);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() > 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic apply_rate(input logic [9:0] value);
        wait_drained(SETTLE_CYCLES);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        tracker.write_rate(value);
        cur_rate = value;
    endtask

    task automatic run_frames(input int n_items);
        int          sent;
        logic [63:0] per;
        logic [63:0] gap;
        logic [63:0] t;
        op_t         op;
        sent = 0;
        per  = (cur_rate >= 1 && cur_rate <= MAX_RATE) ? NS_PER_SECOND / cur_rate : DEFAULT_GAP;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 99) < 75)
            begin
                // well-formed frame: prepare, start around the target, maybe ask again
                if (now_cursor > 64'hFFFF_0000_0000_0000 && $urandom_range(0, 1))
                    now_cursor = {24'd0, $urandom, 8'($urandom)};
                send_op(OP_PREPARE, now_cursor);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: gap = per * $urandom_range(80, 120) / 100;
                    6, 7:             gap = 64'($urandom_range(0, 32'(per / 2)));
                    8:                gap = per * $urandom_range(1, 3) + $urandom_range(0, 1000);
                    default:          gap = per;
                endcase
                now_cursor = later(now_cursor, gap);
                send_op(OP_ACCEPT, now_cursor);
                sent += 2;
                if ($urandom_range(0, 3) == 0)
                begin
                    now_cursor = later(now_cursor, 64'($urandom_range(0, 1000)));
                    send_op(OP_PREPARE, now_cursor);
                    sent++;
                end
            end
            else
            begin
                op = op_t'($urandom_range(0, 3));
                case ($urandom_range(0, 3))
                    0:       t = now_cursor - $urandom_range(1, 5000);
                    1:       t = {$urandom, $urandom};
                    2:       t = TIME_MAX - $urandom_range(0, 3);
                    default: t = later(now_cursor, 64'($urandom_range(0, 1000)));
                endcase
                send_op(op, t);
                if ($urandom_range(0, 1))
                    now_cursor = t;
                if (op != OP_NONE)
                    sent++;
            end
        end
    endtask

    initial
    begin
        logic [9:0] rates[9];
        int         counts[9];
        rates  = '{10'd1, 10'd1000, 10'd0, 10'd7, 10'd1023, 10'($urandom_range(1, 1000)),
                   10'd997, 10'd1001, 10'($urandom_range(1, 1000))};
        counts = '{60, 70, 30, 70, 25, 70, 70, 25, 70};

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_NONE;
        rx_hold_left  = 0;
        cycle_count   = 0;
        tx_idle_pct   = 28;
        rx_idle_pct   = 69;
        cur_rate      = RATE_RESET;
        now_cursor    = 64'd5_000;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: resync, both sides of the max, late restart, backwards time,
        // ignored ops, saturation near the top of the time range
        send_op(OP_PREPARE, 64'd0);
        send_op(OP_PREPARE, 64'd1000);
        send_op(OP_ACCEPT,  64'd16_666_666);
        send_op(OP_PREPARE, 64'd16_670_000);
        send_op(OP_ACCEPT,  64'd33_300_000);
        send_op(OP_PREPARE, 64'd33_300_001);
        send_op(OP_ACCEPT,  64'd200_000_000);
        send_op(OP_PREPARE, 64'd200_000_001);
        send_op(OP_ACCEPT,  64'd100);
        send_op(OP_ACCEPT,  64'd200);
        send_op(OP_PREPARE, 64'd300);
        send_op(OP_PREPARE, 64'd100);
        send_op(OP_NONE,    TIME_MAX);
        send_op(OP_DISABLE, 64'd0);
        send_op(OP_PREPARE, TIME_MAX - 5);
        send_op(OP_PREPARE, TIME_MAX);
        send_op(OP_ACCEPT,  TIME_MAX);
        send_op(OP_PREPARE, TIME_MAX);
        send_op(OP_DISABLE, TIME_MAX);
        send_op(OP_PREPARE, 64'd0);

        for (int p = 0; p < 9; p++)
        begin
            if (p < 3)
            begin
                tx_idle_pct = 28;
                rx_idle_pct = 69;
            end
            else if (p < 6)
            begin
                tx_idle_pct = 69;
                rx_idle_pct = 28;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            apply_rate(rates[p]);
            run_frames(counts[p] / 2);
            wait_drained(0);
            // output side blocked while transfers keep coming, so the block backs up
            if (p % 3 == 1)
                rx_hold_left = HOLD_CYCLES;
            run_frames(counts[p] - counts[p] / 2);
        end

        wait_drained(SETTLE_CYCLES);
        if (tracker.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ files.f @@
hdl/fsp_pkg.sv
hdl/fsp_div.sv
hdl/fsp_dp.sv
hdl/fsp_ctrl.sv
hdl/frame_start_pacer.sv
verif/frame_start_pacer_tb.sv
